@@ design/tcpq_pkg.sv @@
// Package for the three-class priority queue: widths, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none
package tcpq_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int ORDER_BITS_DEF = 16;

    localparam int CMD_W      = 2;
    localparam int CLS_W      = 2;
    localparam int ORDER_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 7;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_CLR = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    typedef enum logic [CLS_W-1:0] {
        CLS_TOP   = 2'd0,
        CLS_MID   = 2'd1,
        CLS_PLAIN = 2'd2
    } t_class;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_read;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic deq_item;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ design/tcpq_ctrl.sv @@
// Controller for the three-class priority queue: handshakes and sequencing.
`timescale 1ns / 1ps
`default_nettype none
module tcpq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_valid,
    output logic                    o_s_ready,
    output logic                    o_m_valid,
    input  wire logic               i_m_ready,
    input  wire tcpq_pkg::t_dp_stat i_stat,
    output tcpq_pkg::t_dp_cmd       o_cmd
);
    import tcpq_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_s_ready = (r_state == S_IDLE) && (!r_out_valid || i_m_ready);
    assign accept    = i_s_valid && o_s_ready;
    assign o_m_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_stat.deq_item) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.accept    = 1'b0;
        o_cmd.load_read = 1'b0;
        n_out_valid     = r_out_valid && !i_m_ready;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = accept;
                if (accept && !i_stat.deq_item) begin
                    n_out_valid = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.load_read = 1'b1;
                n_out_valid     = 1'b1;
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

@@ design/tcpq_dp.sv @@
// Datapath for the three-class priority queue: class rings, counts and result register.
`timescale 1ns / 1ps
`default_nettype none
module tcpq_dp #(
    parameter int CAPACITY   = tcpq_pkg::CAPACITY_DEF,
    parameter int ORDER_BITS = tcpq_pkg::ORDER_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tcpq_pkg::t_dp_cmd             i_cmd,
    output tcpq_pkg::t_dp_stat                 o_stat,
    input  wire logic [tcpq_pkg::IN_DATA_W-1:0]  i_data,
    output logic      [tcpq_pkg::OUT_DATA_W-1:0] o_data
);
    import tcpq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int TOT_W = CNT_W + 2;
    localparam int NCLS  = 3;

    logic [CMD_W-1:0]   cmd_raw;
    logic [CLS_W-1:0]   cls_raw;
    logic [ORDER_W-1:0] ord_in;
    t_class             cls;
    t_class             deq_cls;
    logic [TOT_W-1:0]   total;
    logic [TOT_W-1:0]   n_total;
    logic               full;
    logic               empty;
    logic               enq_ok;
    logic               deq_ok;
    t_status            status;

    logic [IDX_W-1:0] r_head  [NCLS];
    logic [IDX_W-1:0] n_head  [NCLS];
    logic [CNT_W-1:0] r_count [NCLS];
    logic [CNT_W-1:0] n_count [NCLS];
    logic [SUM_W-1:0] wsum    [NCLS];
    logic [SUM_W-1:0] hsum    [NCLS];
    logic [IDX_W-1:0] wpos    [NCLS];
    logic             we      [NCLS];
    logic [ORDER_BITS-1:0] r_rd [NCLS];

    logic                r_valid;
    t_class              r_cls;
    logic [ORDER_W-1:0]  r_ord;
    t_status             r_status;
    logic [LEN_W-1:0]    r_len;
    logic                r_empty;

    assign cmd_raw = i_data[CMD_W-1:0];
    assign cls_raw = i_data[CMD_W+CLS_W-1:CMD_W];
    assign ord_in  = i_data[CMD_W+CLS_W+ORDER_W-1:CMD_W+CLS_W];

    always_comb begin
        unique case (cls_raw)
            CLS_TOP: cls = CLS_TOP;
            CLS_MID: cls = CLS_MID;
            default: cls = CLS_PLAIN;
        endcase
    end

    assign total = TOT_W'(r_count[0]) + TOT_W'(r_count[1]) + TOT_W'(r_count[2]);
    assign full  = total >= TOT_W'(CAPACITY);
    assign empty = (total == '0);

    always_comb begin
        if (r_count[0] != '0) begin
            deq_cls = CLS_TOP;
        end else if (r_count[1] != '0) begin
            deq_cls = CLS_MID;
        end else begin
            deq_cls = CLS_PLAIN;
        end
    end

    assign enq_ok = (cmd_raw == CMD_ENQ) && !full;
    assign deq_ok = (cmd_raw == CMD_DEQ) && !empty;
    assign o_stat.deq_item = deq_ok;

    always_comb begin
        n_total = total;
        status  = ST_OK;
        unique case (cmd_raw)
            CMD_ENQ: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_total = total + TOT_W'(1);
                end
            end
            CMD_DEQ: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_total = total - TOT_W'(1);
                end
            end
            CMD_CLR: n_total = '0;
            default: n_total = total;
        endcase
    end

    // per-class ring arithmetic
    always_comb begin
        for (int k = 0; k < NCLS; k++) begin
            wsum[k] = SUM_W'(r_head[k]) + SUM_W'(r_count[k]);
            hsum[k] = SUM_W'(r_head[k]) + SUM_W'(1);
            if (wsum[k] >= SUM_W'(CAPACITY)) begin
                wpos[k] = IDX_W'(wsum[k] - SUM_W'(CAPACITY));
            end else begin
                wpos[k] = IDX_W'(wsum[k]);
            end
            we[k]      = i_cmd.accept && enq_ok && (cls == t_class'(k));
            n_head[k]  = r_head[k];
            n_count[k] = r_count[k];
            if (i_cmd.accept) begin
                if (cmd_raw == CMD_CLR) begin
                    n_head[k]  = '0;
                    n_count[k] = '0;
                end else if (we[k]) begin
                    n_count[k] = r_count[k] + CNT_W'(1);
                end else if (deq_ok && (deq_cls == t_class'(k))) begin
                    if (hsum[k] >= SUM_W'(CAPACITY)) begin
                        n_head[k] = '0;
                    end else begin
                        n_head[k] = IDX_W'(hsum[k]);
                    end
                    n_count[k] = r_count[k] - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCLS; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NCLS; k++) begin
                r_head[k]  <= n_head[k];
                r_count[k] <= n_count[k];
            end
        end
    end

    // one ring store per class, read at its head
    for (genvar g = 0; g < NCLS; g++) begin : g_store
        logic [ORDER_BITS-1:0] mem [CAPACITY];

        always_ff @(posedge i_clk) begin
            if (we[g]) begin
                mem[wpos[g]] <= ORDER_BITS'(ord_in);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.accept) begin
                r_rd[g] <= mem[r_head[g]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_valid  <= deq_ok;
            r_cls    <= deq_ok ? deq_cls : CLS_TOP;
            r_ord    <= '0;
            r_status <= status;
            r_len    <= LEN_W'(n_total);
            r_empty  <= (n_total == '0);
        end else if (i_cmd.load_read) begin
            case (r_cls)
                CLS_TOP: r_ord <= ORDER_W'(r_rd[0]);
                CLS_MID: r_ord <= ORDER_W'(r_rd[1]);
                default: r_ord <= ORDER_W'(r_rd[2]);
            endcase
        end
    end

    assign o_data = {3'b000, r_empty, r_len, r_status, r_ord, r_cls, r_valid};

endmodule
`default_nettype wire

@@ design/three_class_priority_queue.sv @@
// Top level of the three-class priority queue: controller and datapath.
// Results: enqueue, clear and no-op results are offered in the cycle after acceptance;
//   a dequeue that returns an item is offered later, after the registered ring store read.
// Throughput: 1 transaction per cycle unless the output stalls or a dequeue returns an item.
// Reset: synchronous, active low; empties all classes and clears the output valid flag,
//   store contents are kept and never returned before being written.
`timescale 1ns / 1ps
`default_nettype none
module three_class_priority_queue #(
    parameter int CAPACITY   = tcpq_pkg::CAPACITY_DEF,
    parameter int ORDER_BITS = tcpq_pkg::ORDER_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [1:0] command, [3:2] item_class, [19:4] order_number, [23:20] zero
    input  wire logic [tcpq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] item_valid, [2:1] out_class, [18:3] out_order, [20:19] status,
    // [27:21] queue_length, [28] queue_empty, [31:29] zero
    output logic      [tcpq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tcpq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    tcpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    tcpq_dp #(
        .CAPACITY   (CAPACITY),
        .ORDER_BITS (ORDER_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .i_data  (s_axis_tdata),
        .o_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

@@ tb/sv/tcpq_checker.sv @@
// Result checker for the three-class priority queue: class ring model and result compare.
`timescale 1ns / 1ps
module tcpq_checker
    import tcpq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    // [1:0] command, [3:2] item_class, [19:4] order_number, [23:20] zero
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    // [0] item_valid, [2:1] out_class, [18:3] out_order, [20:19] status,
    // [27:21] queue_length, [28] queue_empty, [31:29] zero
    input  wire logic [OUT_DATA_W-1:0] i_out_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_full_seen,
    output int                         o_empty_seen
);

    localparam int DEPTH = CAPACITY_DEF;

    typedef struct packed {
        logic               item_valid;
        logic [CLS_W-1:0]   out_class;
        logic [ORDER_W-1:0] out_order;
        t_status            status;
        logic [LEN_W-1:0]   queue_length;
        logic               queue_empty;
    } t_queue_result;

    logic [ORDER_W-1:0] held_orders [3][DEPTH];
    int                 ring_head  [3] = '{0, 0, 0};
    int                 class_fill [3] = '{0, 0, 0};
    t_queue_result      results_due [$];
    int                 fails      = 0;
    int                 checked    = 0;
    int                 full_seen  = 0;
    int                 empty_seen = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_seen  = 0;
        o_empty_seen = 0;
    end

    function automatic t_queue_result apply_command(input logic [IN_DATA_W-1:0] data);
        t_cmd          cmd;
        int            cls;
        int            c;
        int            total;
        t_queue_result r;
        cmd   = t_cmd'(data[1:0]);
        cls   = int'(data[3:2]);
        r     = '0;
        total = class_fill[0] + class_fill[1] + class_fill[2];
        // any class code beyond plain counts as plain
        if (cls > CLS_PLAIN)
            cls = CLS_PLAIN;
        case (cmd)
            CMD_ENQ: begin
                if (total >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_orders[cls][(ring_head[cls] + class_fill[cls]) % DEPTH] = data[19:4];
                    class_fill[cls]++;
                end
            end
            CMD_DEQ: begin
                if (total == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    c = CLS_TOP;
                    while (c < CLS_PLAIN && class_fill[c] == 0)
                        c++;
                    r.item_valid = 1'b1;
                    r.out_class  = c[CLS_W-1:0];
                    r.out_order  = held_orders[c][ring_head[c]];
                    ring_head[c] = (ring_head[c] + 1) % DEPTH;
                    class_fill[c]--;
                end
            end
            CMD_CLR: begin
                ring_head  = '{0, 0, 0};
                class_fill = '{0, 0, 0};
            end
            default: ;
        endcase
        total          = class_fill[0] + class_fill[1] + class_fill[2];
        r.queue_length = total[LEN_W-1:0];
        r.queue_empty  = (total == 0);
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result transaction with nothing outstanding: data %h", i_out_data);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    compare_field("item_valid", int'(want.item_valid), int'(i_out_data[0]));
                    compare_field("out_class", int'(want.out_class), int'(i_out_data[2:1]));
                    compare_field("out_order", int'(want.out_order), int'(i_out_data[18:3]));
                    compare_field("status", int'(want.status), int'(i_out_data[20:19]));
                    compare_field("queue_length", int'(want.queue_length),
                                  int'(i_out_data[27:21]));
                    compare_field("queue_empty", int'(want.queue_empty), int'(i_out_data[28]));
                    checked++;
                    if (want.status == ST_FULL)
                        full_seen++;
                    if (want.status == ST_EMPTY)
                        empty_seen++;
                end
            end
            if (i_in_valid && i_in_ready)
                results_due.push_back(apply_command(i_in_data));
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
        o_checked    <= checked;
        o_full_seen  <= full_seen;
        o_empty_seen <= empty_seen;
    end

endmodule

@@ tb/sv/tb_three_class_priority_queue.sv @@
// Testbench top for the three-class priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_three_class_priority_queue;
    import tcpq_pkg::*;

    localparam int              ITEM_TARGET    = 1250;
    localparam int              HOLD_CYCLES    = 200;
    localparam int              WATCHDOG_LIMIT = 3000;
    localparam int              DRAIN_CYCLES   = 10;
    localparam logic [CLS_W-1:0] CLS_SPARE     = 2'd3;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [1:0] command, [3:2] item_class, [19:4] order_number, [23:20] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] item_valid, [2:1] out_class, [18:3] out_order, [20:19] status,
    // [27:21] queue_length, [28] queue_empty, [31:29] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;
    int commands_sent = 0;
    int idle_cycles   = 0;
    bit quiet         = 1'b0;
    bit hold_req      = 1'b0;

    always #5 i_clk = ~i_clk;

    three_class_priority_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tcpq_checker u_queue_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen)
    );

    function automatic logic [ORDER_W-1:0] random_order();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return ORDER_W'($urandom);
    endfunction

    function automatic t_cmd pick_command(input int enq_pct, input int deq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
            return CMD_ENQ;
        if (r < enq_pct + deq_pct)
            return CMD_DEQ;
        return $urandom_range(0, 1) ? CMD_CLR : CMD_NOP;
    endfunction

    task automatic push_command(input t_cmd cmd, input logic [CLS_W-1:0] cls,
                                input logic [ORDER_W-1:0] ord);
        while (!quiet && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, ord, cls, cmd};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        commands_sent++;
    endtask

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_three_class_priority_queue: errors");
                $finish;
            end
        end
    end

    initial begin
        int  kind;
        int  burst;
        bit  hold_used;
        hold_used = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty dequeue, clear and no-op on empty, class ordering, class three
        push_command(CMD_DEQ, CLS_TOP, '0);
        push_command(CMD_CLR, CLS_TOP, '0);
        push_command(CMD_NOP, CLS_SPARE, '1);
        push_command(CMD_ENQ, CLS_PLAIN, '0);
        push_command(CMD_ENQ, CLS_TOP, '1);
        push_command(CMD_ENQ, CLS_MID, 16'h1234);
        push_command(CMD_ENQ, CLS_SPARE, 16'hABCD);
        push_command(CMD_ENQ, CLS_TOP, 16'h0001);
        push_command(CMD_NOP, CLS_MID, 16'h5A5A);
        repeat (6) push_command(CMD_DEQ, CLS_TOP, '0);
        push_command(CMD_ENQ, CLS_MID, '1);
        push_command(CMD_ENQ, CLS_PLAIN, 16'h8000);
        push_command(CMD_CLR, CLS_SPARE, '1);
        push_command(CMD_DEQ, CLS_SPARE, '1);
        push_command(CMD_ENQ, CLS_TOP, 16'h5555);
        push_command(CMD_DEQ, CLS_MID, 16'hAAAA);

        while (commands_sent < ITEM_TARGET) begin
            quiet = (commands_sent >= 600 && commands_sent < 800);
            if (!hold_used && commands_sent >= 300) begin
                hold_used = 1'b1;
                hold_req  = 1'b1;
            end
            kind  = $urandom_range(0, 99);
            burst = $urandom_range(8, 40);
            if (kind < 8) begin
                // fill past capacity, then drain past empty
                push_command(CMD_CLR, CLS_W'($urandom_range(0, 3)), random_order());
                repeat ($urandom_range(66, 72))
                    push_command(CMD_ENQ, CLS_W'($urandom_range(0, 3)), random_order());
                repeat ($urandom_range(66, 72))
                    push_command(CMD_DEQ, CLS_W'($urandom_range(0, 3)), random_order());
            end else if (kind < 35) begin
                repeat (burst)
                    push_command(pick_command(70, 25), CLS_W'($urandom_range(0, 3)),
                                 random_order());
            end else if (kind < 65) begin
                repeat (burst)
                    push_command(pick_command(30, 65), CLS_W'($urandom_range(0, 3)),
                                 random_order());
            end else begin
                repeat (burst)
                    push_command(pick_command(48, 48), CLS_W'($urandom_range(0, 3)),
                                 random_order());
            end
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        // let the checker's count take in the last transaction
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d queue commands and checked %0d results, with one long output stall.",
                 commands_sent, checked);
        $display("Enqueues refused on a full queue: %0d; dequeues from an empty queue: %0d.",
                 full_seen, empty_seen);
        if (fail_count == 0)
            $display("tb_three_class_priority_queue: clean");
        else
            $display("tb_three_class_priority_queue: errors");
        $finish;
    end

endmodule

@@ three_class_priority_queue.f @@
design/tcpq_pkg.sv
design/tcpq_ctrl.sv
design/tcpq_dp.sv
design/three_class_priority_queue.sv
tb/sv/tcpq_checker.sv
tb/sv/tb_three_class_priority_queue.sv
